>>> hw/rtl/mtpl_pkg.sv
`timescale 1ns / 1ps
package mtpl_pkg;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_HIT      = 2'd1;
  localparam logic [1:0] ST_MISS     = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  localparam int unsigned AddrBits  = 32;
  localparam int unsigned MaxLevels = 8;

  typedef struct packed {
    logic        req_type;
    logic [31:0] addr;
    logic [5:0]  prefix_len;
    logic [7:0]  out_port;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] match_addr;
    logic [5:0]  match_len;
    logic [7:0]  match_port;
  } rsp_t;

endpackage

>>> hw/rtl/multibit_trie_prefix_lookup_top.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake               | Word
// req     | in        | req_valid_i/req_stall_o | mtpl_pkg::req_t
// rsp     | out       | rsp_valid_o/rsp_stall_i | mtpl_pkg::rsp_t
// One word at a time through one slot memory port (read, then write per slot).
// Each item: the word is taken in idle, then each slot visited is read and
// evaluated, then the response is given. Lookup visits 1..8 slots; insert visits
// its walked levels plus 1..16 expanded slots.
// After reset a clearing pass writes NODE_COUNT*16 slots, one per cycle; no word
// is taken meanwhile. The response sits in an output register until not stalled,
// and no new word is taken while it waits.
module multibit_trie_prefix_lookup_top #(
  parameter int unsigned NODE_COUNT = 1024
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_stall_o,
  input  mtpl_pkg::req_t  req_i,
  output logic            rsp_valid_o,
  input  logic            rsp_stall_i,
  output mtpl_pkg::rsp_t  rsp_o
);

  localparam int unsigned NodeBits  = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int unsigned CntBits   = $clog2(NODE_COUNT + 1);
  localparam int unsigned SlotBits  = NodeBits + 4;
  localparam int unsigned Depth     = NODE_COUNT * 16;

  typedef struct packed {
    logic [NodeBits-1:0] child;
    logic                pvalid;
    logic [31:0]         paddr;
    logic [5:0]          plen;
    logic [7:0]          pport;
  } slot_t;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  slot_t mem_q [Depth];
  slot_t rd_q;

  logic [2:0]          state_q, state_d;
  logic [SlotBits-1:0] clr_q, clr_d;
  logic [CntBits-1:0]  free_q, free_d;
  mtpl_pkg::req_t      req_q, req_d;
  logic [NodeBits-1:0] node_q, node_d;
  logic [2:0]          level_q, level_d;
  logic [2:0]          target_q, target_d;
  logic                expand_q, expand_d;
  logic [3:0]          k_q, k_d;
  logic [3:0]          kmax_q, kmax_d;
  logic [3:0]          base_q, base_d;
  mtpl_pkg::rsp_t      rsp_q, rsp_d;
  logic                found_q, found_d;

  logic                we;
  logic [SlotBits-1:0] waddr, raddr;
  slot_t               wdata;

  logic [5:0] len_sat;
  logic [5:0] len_m1;
  logic [3:0] nib;
  logic [2:0] rem;

  assign len_sat = (req_i.prefix_len > 6'd32) ? 6'd32 : req_i.prefix_len;
  assign len_m1  = len_sat - 6'd1;

  // Current address nibble for the walk level
  always_comb begin
    nib = req_q.addr[5'd28 - {level_q, 2'b00} +: 4];
  end

  assign raddr = expand_q ? {node_q, base_q | k_q} : {node_q, nib};

  // Memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rd_q <= mem_q[raddr];
  end

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    free_d   = free_q;
    req_d    = req_q;
    node_d   = node_q;
    level_d  = level_q;
    target_d = target_q;
    expand_d = expand_q;
    k_d      = k_q;
    kmax_d   = kmax_q;
    base_d   = base_q;
    rsp_d    = rsp_q;
    found_d  = found_q;
    we       = 1'b0;
    waddr    = raddr;
    wdata    = rd_q;
    rem      = 3'd0;
    unique case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == SlotBits'(Depth - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid_i) begin
          req_d         = req_i;
          req_d.prefix_len = len_sat;
          node_d        = '0;
          level_d       = '0;
          k_d           = '0;
          found_d       = 1'b0;
          rsp_d         = '0;
          if (req_i.req_type == mtpl_pkg::REQ_INSERT) begin
            target_d = (len_sat == 6'd0) ? 3'd0 : len_m1[4:2];
            rem      = (len_sat == 6'd0) ? 3'd0 : 3'd1 + {1'b0, len_m1[1:0]};
            // Expand stage starts at once when no full nibble is walked
            expand_d = (len_sat == 6'd0) || (len_m1[4:2] == 3'd0);
            kmax_d   = 4'((5'd1 << (3'd4 - rem)) - 5'd1);
            base_d   = req_i.addr[31:28] & ~kmax_d;
            if (len_sat > 6'd4) base_d = req_i.addr[5'd28 - {len_m1[4:2], 2'b00} +: 4] & ~kmax_d;
          end else begin
            expand_d = 1'b0;
          end
          state_d = S_READ;
        end
      end
      S_READ: state_d = S_EVAL;
      S_EVAL: begin
        if (req_q.req_type == mtpl_pkg::REQ_LOOKUP) begin
          if (rd_q.pvalid) begin
            found_d          = 1'b1;
            rsp_d.match_addr = rd_q.paddr;
            rsp_d.match_len  = rd_q.plen;
            rsp_d.match_port = rd_q.pport;
          end
          if (rd_q.child == '0 || level_q == 3'd7) begin
            rsp_d.status = (found_d) ? mtpl_pkg::ST_HIT : mtpl_pkg::ST_MISS;
            if (!found_d) rsp_d = '0;
            if (!found_d) rsp_d.status = mtpl_pkg::ST_MISS;
            state_d = S_RESP;
          end else begin
            node_d  = rd_q.child;
            level_d = level_q + 1'b1;
            state_d = S_READ;
          end
        end else if (!expand_q) begin
          // Walk, allocating a child where none exists
          if (rd_q.child == '0) begin
            if (free_q >= CntBits'(NODE_COUNT)) begin
              rsp_d        = '0;
              rsp_d.status = mtpl_pkg::ST_FULL;
              state_d      = S_RESP;
            end else begin
              we          = 1'b1;
              wdata.child = free_q[NodeBits-1:0];
              node_d      = free_q[NodeBits-1:0];
              free_d      = free_q + 1'b1;
              state_d     = S_READ;
            end
          end else begin
            node_d  = rd_q.child;
            state_d = S_READ;
          end
          if (state_d == S_READ) begin
            level_d = level_q + 1'b1;
            if (level_q + 3'd1 == target_q) expand_d = 1'b1;
          end
        end else begin
          // Expand over the slot range, longer or equal prefixes win
          if (!rd_q.pvalid || req_q.prefix_len >= rd_q.plen) begin
            we           = 1'b1;
            wdata.pvalid = 1'b1;
            wdata.paddr  = req_q.addr;
            wdata.plen   = req_q.prefix_len;
            wdata.pport  = req_q.out_port;
          end
          if (k_q == kmax_q) begin
            rsp_d        = '0;
            rsp_d.status = mtpl_pkg::ST_INSERTED;
            state_d      = S_RESP;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = S_READ;
          end
        end
      end
      S_RESP: if (!rsp_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      free_q   <= CntBits'(1);
      expand_q <= 1'b0;
      found_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      free_q   <= free_d;
      expand_q <= expand_d;
      found_q  <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    node_q   <= node_d;
    level_q  <= level_d;
    target_q <= target_d;
    k_q      <= k_d;
    kmax_q   <= kmax_d;
    base_q   <= base_d;
    rsp_q    <= rsp_d;
  end

  assign req_stall_o = (state_q != S_IDLE);
  assign rsp_valid_o = (state_q == S_RESP);
  assign rsp_o       = rsp_q;

endmodule

>>> hw/rtl/mtpl_checker.sv
`timescale 1ns / 1ps
module mtpl_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           req_valid_i,
  input logic           req_stall_o,
  input logic           rsp_valid_o,
  input logic           rsp_stall_i,
  input mtpl_pkg::rsp_t rsp_o
);

  // Busy while a response is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> req_stall_o) else $error("accepting while response pending");

  // Taking a word makes the block busy on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && !req_stall_o |=> req_stall_o)
    else $error("not busy after taking a word");

  // Stalled response holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_stall_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("stalled response changed");

  // Non-hit results carry zero fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.status != mtpl_pkg::ST_HIT |->
      rsp_o.match_addr == '0 && rsp_o.match_len == '0 && rsp_o.match_port == '0)
    else $error("fields set on non-hit");

  // Hit length within range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.status == mtpl_pkg::ST_HIT |-> rsp_o.match_len <= 6'd32)
    else $error("hit length out of range");

endmodule

bind multibit_trie_prefix_lookup_top mtpl_checker u_mtpl_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .req_valid_i(req_valid_i), .req_stall_o(req_stall_o),
  .rsp_valid_o(rsp_valid_o), .rsp_stall_i(rsp_stall_i), .rsp_o(rsp_o)
);

>>> verif/multibit_trie_prefix_lookup_top_tb.sv
`timescale 1ns / 1ps
module multibit_trie_prefix_lookup_top_tb;

  localparam int unsigned NODES = 1024;
  localparam int unsigned SLOTS = NODES * 16;
  localparam int unsigned RAND_WORDS = 1600;
  localparam int unsigned IDLE_LIMIT = 60000;
  localparam int unsigned TAIL_CYCLES = 60;

  logic clk_i;
  logic rst_ni;
  logic req_valid_i;
  logic req_stall_o;
  mtpl_pkg::req_t req_i;
  logic rsp_valid_o;
  logic rsp_stall_i;
  mtpl_pkg::rsp_t rsp_o;

  multibit_trie_prefix_lookup_top #(.NODE_COUNT(NODES)) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .req_valid_i(req_valid_i),
    .req_stall_o(req_stall_o),
    .req_i(req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_stall_i(rsp_stall_i),
    .rsp_o(rsp_o)
  );

  // Shadow trie
  logic [10:0] trie_child [SLOTS];
  bit          trie_pvalid [SLOTS];
  logic [31:0] trie_paddr [SLOTS];
  logic [5:0]  trie_plen [SLOTS];
  logic [7:0]  trie_pport [SLOTS];
  int unsigned trie_next_node;

  mtpl_pkg::rsp_t pending_rsp_q[$];
  bit   failed;
  int unsigned idle_cycles;

  typedef struct {
    mtpl_pkg::req_t word;
    bit   known;
    mtpl_pkg::rsp_t rsp;
  } dir_row_t;

  dir_row_t dir_rows[$];
  logic [31:0] addr_pool [32];

  function automatic int unsigned nibble_of(logic [31:0] a, int unsigned lvl);
    return (a >> (28 - 4 * lvl)) & 32'hf;
  endfunction

  // Apply one request word to the shadow trie and return its response
  function automatic mtpl_pkg::rsp_t trie_apply(mtpl_pkg::req_t w);
    mtpl_pkg::rsp_t r;
    int unsigned len, tgt, rem, base, cnt, node, nib, idx, lvl;
    r = '0;
    node = 0;
    if (w.req_type == mtpl_pkg::REQ_INSERT) begin
      len = (w.prefix_len > 32) ? 32 : w.prefix_len;
      tgt = (len == 0) ? 0 : (len - 1) / 4;
      for (lvl = 0; lvl < tgt; lvl++) begin
        idx = node * 16 + nibble_of(w.addr, lvl);
        if (trie_child[idx] == 0) begin
          if (trie_next_node >= NODES) begin
            r.status = mtpl_pkg::ST_FULL;
            return r;
          end
          trie_child[idx] = 11'(trie_next_node);
          trie_next_node++;
        end
        node = 32'(trie_child[idx]);
      end
      // expand the leftover bits over the final node
      rem = len - 4 * tgt;
      nib = nibble_of(w.addr, tgt);
      base = (rem == 0) ? 0 : ((nib >> (4 - rem)) << (4 - rem));
      cnt = 1 << (4 - rem);
      for (int unsigned k = 0; k < cnt; k++) begin
        idx = node * 16 + base + k;
        if (!trie_pvalid[idx] || len >= trie_plen[idx]) begin
          trie_pvalid[idx] = 1'b1;
          trie_paddr[idx] = w.addr;
          trie_plen[idx] = 6'(len);
          trie_pport[idx] = w.out_port;
        end
      end
      r.status = mtpl_pkg::ST_INSERTED;
    end else begin
      r.status = mtpl_pkg::ST_MISS;
      for (lvl = 0; lvl < mtpl_pkg::MaxLevels; lvl++) begin
        idx = node * 16 + nibble_of(w.addr, lvl);
        if (trie_pvalid[idx]) begin
          r.status = mtpl_pkg::ST_HIT;
          r.match_addr = trie_paddr[idx];
          r.match_len = trie_plen[idx];
          r.match_port = trie_pport[idx];
        end
        if (trie_child[idx] == 0) break;
        node = 32'(trie_child[idx]);
      end
    end
    return r;
  endfunction

  function automatic mtpl_pkg::req_t mk_word(logic t, logic [31:0] a, logic [5:0] l,
                                             logic [7:0] p);
    mtpl_pkg::req_t w;
    w.req_type = t;
    w.addr = a;
    w.prefix_len = l;
    w.out_port = p;
    return w;
  endfunction

  function automatic void add_row(mtpl_pkg::req_t w, bit known, mtpl_pkg::rsp_t r);
    dir_row_t row;
    row.word = w;
    row.known = known;
    row.rsp = r;
    dir_rows.push_back(row);
  endfunction

  function automatic mtpl_pkg::rsp_t mk_rsp(logic [1:0] s, logic [31:0] a, logic [5:0] l,
                                            logic [7:0] p);
    mtpl_pkg::rsp_t r;
    r.status = s;
    r.match_addr = a;
    r.match_len = l;
    r.match_port = p;
    return r;
  endfunction

  // Random word: inserts and lookups, mostly around a shared address pool
  function automatic mtpl_pkg::req_t rand_word();
    mtpl_pkg::req_t w;
    logic [31:0] a;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    a = addr_pool[$urandom_range(0, 31)];
    if (sel < 70) a = a ^ ($urandom() >> $urandom_range(4, 32));
    else a = $urandom();
    w.addr = a;
    w.req_type = ($urandom_range(0, 99) < 50) ? mtpl_pkg::REQ_INSERT : mtpl_pkg::REQ_LOOKUP;
    sel = $urandom_range(0, 99);
    if (sel < 4) w.prefix_len = '0;
    else if (sel < 10) w.prefix_len = 6'($urandom_range(33, 63));
    else if (sel < 40) w.prefix_len = 6'($urandom_range(1, 16));
    else w.prefix_len = 6'($urandom_range(1, 32));
    w.out_port = 8'($urandom_range(0, 255));
    return w;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Drive one word and hold it until accepted
  task automatic send_word(mtpl_pkg::req_t w, bit known, mtpl_pkg::rsp_t r);
    mtpl_pkg::rsp_t p;
    req_valid_i <= 1'b1;
    req_i <= w;
    do @(posedge clk_i); while (req_stall_o);
    p = trie_apply(w);
    if (known && p !== r) begin
      $display("%0t predictor disagrees with table: expected %h, actual %h", $time, r, p);
      failed = 1'b1;
    end
    pending_rsp_q.push_back(known ? r : p);
  endtask

  // Bursts of words with random gaps between them
  task automatic pace();
    static int unsigned burst_left = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      req_valid_i <= 1'b0;
      req_i <= rand_word();
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(0, 20);
    end
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      trie_child[i] = '0;
      trie_pvalid[i] = 1'b0;
      trie_paddr[i] = '0;
      trie_plen[i] = '0;
      trie_pport[i] = '0;
    end
    trie_next_node = 1;
    for (int i = 0; i < 32; i++) addr_pool[i] = $urandom();
    failed = 1'b0;
    rst_ni = 1'b0;
    req_valid_i = 1'b0;
    req_i = '0;

    // Directed rows: empty table, default route, extremes, short lengths
    add_row(mk_word(mtpl_pkg::REQ_LOOKUP, 32'h0, 6'd0, 8'h0), 1,
            mk_rsp(mtpl_pkg::ST_MISS, '0, '0, '0));
    add_row(mk_word(mtpl_pkg::REQ_LOOKUP, 32'hffffffff, 6'd63, 8'hff), 1,
            mk_rsp(mtpl_pkg::ST_MISS, '0, '0, '0));
    add_row(mk_word(mtpl_pkg::REQ_INSERT, 32'hdeadbeef, 6'd0, 8'h05), 1,
            mk_rsp(mtpl_pkg::ST_INSERTED, '0, '0, '0));
    add_row(mk_word(mtpl_pkg::REQ_LOOKUP, 32'h0, 6'd0, 8'h0), 1,
            mk_rsp(mtpl_pkg::ST_HIT, 32'hdeadbeef, 6'd0, 8'h05));
    add_row(mk_word(mtpl_pkg::REQ_INSERT, 32'hffffffff, 6'd32, 8'hff), 1,
            mk_rsp(mtpl_pkg::ST_INSERTED, '0, '0, '0));
    add_row(mk_word(mtpl_pkg::REQ_LOOKUP, 32'hffffffff, 6'd0, 8'h0), 1,
            mk_rsp(mtpl_pkg::ST_HIT, 32'hffffffff, 6'd32, 8'hff));
    add_row(mk_word(mtpl_pkg::REQ_INSERT, 32'h12345678, 6'd63, 8'h11), 1,
            mk_rsp(mtpl_pkg::ST_INSERTED, '0, '0, '0));
    add_row(mk_word(mtpl_pkg::REQ_LOOKUP, 32'h12345678, 6'd0, 8'h0), 1,
            mk_rsp(mtpl_pkg::ST_HIT, 32'h12345678, 6'd32, 8'h11));
    add_row(mk_word(mtpl_pkg::REQ_INSERT, 32'h80000000, 6'd1, 8'h21), 0, '0);
    add_row(mk_word(mtpl_pkg::REQ_INSERT, 32'hc0ffffff, 6'd2, 8'h22), 0, '0);
    add_row(mk_word(mtpl_pkg::REQ_INSERT, 32'ha0000000, 6'd3, 8'h23), 0, '0);
    add_row(mk_word(mtpl_pkg::REQ_INSERT, 32'h90000000, 6'd4, 8'h24), 0, '0);
    add_row(mk_word(mtpl_pkg::REQ_INSERT, 32'h98000000, 6'd5, 8'h25), 0, '0);
    add_row(mk_word(mtpl_pkg::REQ_INSERT, 32'h98000000, 6'd1, 8'h26), 0, '0);
    add_row(mk_word(mtpl_pkg::REQ_LOOKUP, 32'h98765432, 6'd0, 8'h0), 0, '0);
    add_row(mk_word(mtpl_pkg::REQ_LOOKUP, 32'hb1234567, 6'd0, 8'h0), 0, '0);
    add_row(mk_word(mtpl_pkg::REQ_LOOKUP, 32'hc8000000, 6'd0, 8'h0), 0, '0);
    add_row(mk_word(mtpl_pkg::REQ_LOOKUP, 32'h12345670, 6'd0, 8'h0), 0, '0);
    add_row(mk_word(mtpl_pkg::REQ_INSERT, 32'h12345670, 6'd28, 8'h77), 0, '0);
    add_row(mk_word(mtpl_pkg::REQ_LOOKUP, 32'h1234567f, 6'd0, 8'h0), 0, '0);
    add_row(mk_word(mtpl_pkg::REQ_LOOKUP, 32'h12345678, 6'd0, 8'h0), 0, '0);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].word, dir_rows[i].known, dir_rows[i].rsp);
      pace();
    end
    for (int unsigned n = 0; n < RAND_WORDS; n++) begin
      send_word(rand_word(), 0, '0);
      pace();
    end
    req_valid_i <= 1'b0;

    // Drain and let the block settle
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (!failed) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Receiver stall: alternate calm stretches and busy stretches
  initial begin
    int unsigned phase_left;
    int unsigned stall_pct;
    rsp_stall_i = 1'b0;
    phase_left = 0;
    stall_pct = 0;
    forever begin
      @(posedge clk_i);
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 200);
        stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 80);
      end
      phase_left--;
      rsp_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Compare each accepted response word with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o && !rsp_stall_i) begin
      if (pending_rsp_q.size() == 0) begin
        $display("%0t unexpected response: expected none, actual %h", $time, rsp_o);
        failed = 1'b1;
      end else begin
        mtpl_pkg::rsp_t exp_rsp;
        exp_rsp = pending_rsp_q.pop_front();
        if (rsp_o.status !== exp_rsp.status) begin
          $display("%0t status: expected %0d, actual %0d", $time, exp_rsp.status,
                   rsp_o.status);
          failed = 1'b1;
        end
        if (rsp_o.match_addr !== exp_rsp.match_addr) begin
          $display("%0t match_addr: expected %h, actual %h", $time, exp_rsp.match_addr,
                   rsp_o.match_addr);
          failed = 1'b1;
        end
        if (rsp_o.match_len !== exp_rsp.match_len) begin
          $display("%0t match_len: expected %0d, actual %0d", $time, exp_rsp.match_len,
                   rsp_o.match_len);
          failed = 1'b1;
        end
        if (rsp_o.match_port !== exp_rsp.match_port) begin
          $display("%0t match_port: expected %h, actual %h", $time, exp_rsp.match_port,
                   rsp_o.match_port);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog: end the run when no word moves for too long
  always @(posedge clk_i) begin
    if ((req_valid_i && !req_stall_o) || (rsp_valid_o && !rsp_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial idle_cycles = 0;

endmodule
